FILE: design/cartridge_bank_controller_unit_defines.svh
// Assertion helpers for the files that check their own logic.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartridge bank controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartridge bank controller check failed");

`endif

FILE: design/cbc_pkg.sv
package cbc_pkg;

   // Bytes in one cartridge RAM bank, and the widest RAM index (four banks).
   localparam int BANK_BYTES = 8192;
   localparam int RAM_INDEX_W = 15;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // What the back has to do with a job.
   localparam logic [1:0] JOB_PLAIN     = 2'd0;
   localparam logic [1:0] JOB_RAM_READ  = 2'd1;
   localparam logic [1:0] JOB_RAM_WRITE = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [15:0] bus_address;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        rom_access;
      logic [18:0] rom_address;
      logic        save_pending;
   } rsp_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [RAM_INDEX_W-1:0] ram_index;
      logic [7:0]             write_data;
      rsp_type                rsp;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic dirty;
   } front_stat_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

FILE: design/cbc_ram.sv
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/cbc_front.sv
module cbc_front #(
   parameter int BANK_COUNT = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cbc_pkg::req_type        req_payload,
   input  logic                    hold,
   input  logic                    csr_valid,
   input  logic                    csr_write_data,
   output logic                    push,
   output cbc_pkg::job_type        job,
   output cbc_pkg::front_stat_type stat
);

   // Address regions, one for each 8 KiB slice of the bus.
   localparam logic [2:0] REGION_LOW0    = 3'd0;
   localparam logic [2:0] REGION_LOW1    = 3'd1;
   localparam logic [2:0] REGION_BANKED0 = 3'd2;
   localparam logic [2:0] REGION_BANKED1 = 3'd3;
   localparam logic [2:0] REGION_WINDOW  = 3'd5;
   localparam logic [3:0] ENABLE_CODE    = 4'hA;
   localparam logic [2:0] BANK_LIMIT     = 3'(BANK_COUNT);

   logic       battery_ff;
   logic       ram_enable_ff, ram_enable_in;
   logic [4:0] rom_bank_ff, rom_bank_in;
   logic [1:0] ram_bank_ff, ram_bank_in;
   logic       dirty_ff, dirty_in;
   logic       accept;
   logic       ram_ok;
   logic [2:0] region;
   logic [4:0] rom_bank_eff;

   assign req_stall = hold;
   assign accept    = req_valid && !hold;
   assign push      = accept;
   assign region    = req_payload.bus_address[15:13];
   assign ram_ok    = ram_enable_ff && ({1'b0, ram_bank_ff} < BANK_LIMIT);
   // Bank zero in the switchable slot maps to bank one.
   assign rom_bank_eff = (rom_bank_ff == 5'd0) ? 5'd1 : rom_bank_ff;

   always_comb begin
      ram_enable_in = ram_enable_ff;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      dirty_in      = dirty_ff;
      job.kind       = cbc_pkg::JOB_PLAIN;
      job.ram_index  = {ram_bank_ff, req_payload.bus_address[12:0]};
      job.write_data = req_payload.write_byte;
      job.rsp        = '0;
      if (req_payload.mode) begin
         // The banking mode slice is written without any effect.
         unique case (region)
            REGION_LOW0: begin
               ram_enable_in = (req_payload.write_byte[3:0] == ENABLE_CODE);
            end
            REGION_LOW1: begin
               rom_bank_in = req_payload.write_byte[4:0];
            end
            REGION_BANKED0: begin
               ram_bank_in = req_payload.write_byte[1:0];
            end
            REGION_WINDOW: begin
               if (ram_ok) begin
                  job.kind = cbc_pkg::JOB_RAM_WRITE;
                  if (battery_ff) begin
                     dirty_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         job.rsp.save_pending = dirty_in;
      end else begin
         unique case (region) inside
            REGION_LOW0, REGION_LOW1: begin
               job.rsp.rom_access  = 1'b1;
               job.rsp.rom_address = {5'd0, req_payload.bus_address[13:0]};
            end
            REGION_BANKED0, REGION_BANKED1: begin
               job.rsp.rom_access  = 1'b1;
               job.rsp.rom_address = {rom_bank_eff, req_payload.bus_address[13:0]};
            end
            REGION_WINDOW: begin
               if (ram_ok) begin
                  job.kind = cbc_pkg::JOB_RAM_READ;
               end else begin
                  job.rsp.read_byte = 8'hFF;
               end
            end
            default: begin
               job.rsp.read_byte = 8'hFF;
            end
         endcase
         job.rsp.save_pending = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         battery_ff    <= 1'b0;
         ram_enable_ff <= 1'b0;
         rom_bank_ff   <= 5'd0;
         ram_bank_ff   <= 2'd0;
         dirty_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            battery_ff <= csr_write_data;
         end
         if (accept) begin
            ram_enable_ff <= ram_enable_in;
            rom_bank_ff   <= rom_bank_in;
            ram_bank_ff   <= ram_bank_in;
            dirty_ff      <= dirty_in;
         end
      end
   end

   assign stat.dirty = dirty_ff;

endmodule

FILE: design/cbc_queue.sv
module cbc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cbc_pkg::job_type        push_job,
   input  logic                    pop,
   output cbc_pkg::job_type        head,
   output cbc_pkg::queue_stat_type stat
);

   localparam int PTR_W = (cbc_pkg::QUEUE_DEPTH > 1) ? $clog2(cbc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(cbc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(cbc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(cbc_pkg::QUEUE_DEPTH);

   cbc_pkg::job_type slots_ff [cbc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head       = slots_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FULL_COUNT);
   assign stat.empty = (count_ff == '0);

endmodule

FILE: design/cbc_back.sv
module cbc_back #(
   parameter int BANK_COUNT = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cbc_pkg::job_type        head,
   input  cbc_pkg::queue_stat_type q_stat,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cbc_pkg::rsp_type        rsp_payload,
   output cbc_pkg::back_stat_type  stat
);

   localparam int RAM_DEPTH = BANK_COUNT * cbc_pkg::BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam logic [RAM_AW-1:0] LAST_INDEX = RAM_AW'(RAM_DEPTH - 1);

   logic              clear_ff;
   logic [RAM_AW-1:0] clear_addr_ff;
   logic              s1_valid_ff;
   cbc_pkg::job_type  s1_job_ff;
   logic              out_valid_ff;
   cbc_pkg::rsp_type  out_ff, out_in;
   logic              out_free, s1_move, s1_free, issue;
   logic              ram_we, ram_re;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || s1_move;
   assign issue    = !clear_ff && !q_stat.empty && s1_free;
   assign pop      = issue;

   // The read data register only moves on a new read, so a held stage keeps its byte.
   assign ram_re    = issue && (head.kind == cbc_pkg::JOB_RAM_READ);
   assign ram_we    = clear_ff || (issue && (head.kind == cbc_pkg::JOB_RAM_WRITE));
   assign ram_addr  = clear_ff ? clear_addr_ff : head.ram_index[RAM_AW-1:0];
   assign ram_wdata = clear_ff ? 8'd0 : head.write_data;

   cbc_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .re   (ram_re),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      out_in = s1_job_ff.rsp;
      if (s1_job_ff.kind == cbc_pkg::JOB_RAM_READ) begin
         out_in.read_byte = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_job_ff <= head;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_INDEX) begin
               clear_ff <= 1'b0;
            end
         end
         if (s1_free) begin
            s1_valid_ff <= issue;
         end
         if (out_free) begin
            out_valid_ff <= s1_move;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_payload   = out_ff;
   assign stat.clearing = clear_ff;

endmodule

FILE: design/cartridge_bank_controller_unit.sv
// An accepted request is registered in the queue, then in the back stage with the RAM
// access, then in the output register.  Throughput: one request per cycle unless stalled,
// set by the single port of the cartridge RAM.  Reset: synchronous and active high; it
// clears the bank registers, the save flag and the battery setting, then the RAM is swept
// to zero at one byte per cycle; meanwhile no request is accepted (CSR writes still are).
`include "cartridge_bank_controller_unit_defines.svh"

module cartridge_bank_controller_unit #(
   parameter int BANK_COUNT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbc_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_write_data
);

   // The front decodes each request against the bank registers it owns, so control
   // writes and the save flag take effect in request order.  Everything but the RAM
   // byte itself is worked out there and travels with the job through the queue.
   // The back owns the RAM: it issues one access per cycle unless its stage is held, keeps
   // the job while the RAM registers the read byte, then loads the output register.

   cbc_pkg::job_type        front_job;
   cbc_pkg::job_type        head_job;
   cbc_pkg::queue_stat_type q_stat;
   cbc_pkg::front_stat_type f_stat;
   cbc_pkg::back_stat_type  b_stat;
   logic                    push;
   logic                    pop;
   logic                    hold;

   // The battery setting is a plain register, always ready for a write.
   assign csr_ready = 1'b1;

   // New requests wait while the RAM is being cleared or the queue has no room.
   assign hold = b_stat.clearing || q_stat.full;

   cbc_front #(
      .BANK_COUNT(BANK_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .hold          (hold),
      .csr_valid     (csr_valid),
      .csr_write_data(csr_write_data),
      .push          (push),
      .job           (front_job),
      .stat          (f_stat)
   );

   cbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(front_job),
      .pop     (pop),
      .head    (head_job),
      .stat    (q_stat)
   );

   cbc_back #(
      .BANK_COUNT(BANK_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .stat       (b_stat)
   );

   // The queue must never be written while it is full.
   `CBC_ASSERT_NOW(a_no_overflow, clock, reset, q_stat.full, !push)
   // No response can appear before the RAM sweep has finished.
   `CBC_ASSERT_NOW(a_quiet_while_clearing, clock, reset, b_stat.clearing, !rsp_valid)
   // Once set, the save flag stays set until reset.
   `CBC_ASSERT_NEXT(a_dirty_sticky, clock, reset, f_stat.dirty, f_stat.dirty)
   // Nothing can be popped from an empty queue.
   `CBC_ASSERT_NOW(a_no_underflow, clock, reset, q_stat.empty, !pop)

endmodule
